// File: hw/rtl/kts_pkg.sv
package kts_pkg;

	typedef enum logic [3:0] {
		KIND_PROGRAM  = 4'd0,
		KIND_VAR      = 4'd1,
		KIND_BEGIN    = 4'd2,
		KIND_END      = 4'd3,
		KIND_INTEGER  = 4'd4,
		KIND_IDENT    = 4'd5,
		KIND_CONSTANT = 4'd6,
		KIND_DOT      = 4'd7,
		KIND_COMMA    = 4'd8,
		KIND_COLON    = 4'd9,
		KIND_SEMI     = 4'd10,
		KIND_EQUALS   = 4'd11,
		KIND_ASSIGN   = 4'd12,
		KIND_UNKNOWN  = 4'd13
	} kind_t;

	// Keywords packed first character highest, right-aligned in the window.
	localparam logic [55:0] KW_PROGRAM = 56'h70726F6772616D;
	localparam logic [55:0] KW_VAR     = 56'h766172;
	localparam logic [55:0] KW_BEGIN   = 56'h626567696E;
	localparam logic [55:0] KW_END     = 56'h656E64;
	localparam logic [55:0] KW_INTEGER = 56'h696E7465676572;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  length;
		logic        sat;
		logic [31:0] offset;
		logic        last;
	} res_t;

	// Up to two tokens per input transaction; push1 is only set with push0.
	typedef struct packed {
		logic push0;
		logic push1;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic kind_t word_kind(input logic [55:0] window, input logic [7:0] len,
			input logic ovf);
		kind_t k;
		k = KIND_IDENT;
		if (!ovf) begin
			priority if (len == 8'd7 && window == KW_PROGRAM) k = KIND_PROGRAM;
			else if (len == 8'd3 && window == KW_VAR) k = KIND_VAR;
			else if (len == 8'd5 && window == KW_BEGIN) k = KIND_BEGIN;
			else if (len == 8'd3 && window == KW_END) k = KIND_END;
			else if (len == 8'd7 && window == KW_INTEGER) k = KIND_INTEGER;
			else k = KIND_IDENT;
		end
		return k;
	endfunction

endpackage

// File: hw/rtl/keyword_token_scanner_top.sv
// The first token of a character transaction passes the input register and then the
// result queue before m_tvalid rises; a full queue can stall it in the input register.
// Throughput: one input transaction per cycle while the queue has room; output drains
// one token per cycle while m_tready is high; tokens beyond that wait in a 4-entry queue.
// The input register refills while the queue has two free entries.
// Reset (arst_n low, asynchronous): scanner idle, offset counter zero, queue empty.
module keyword_token_scanner_top #(
	parameter int LENGTH_LIMIT = 255,
	parameter int OFFSET_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] command (1 = flush)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] token_kind, [11:4] token_length,
	                               // [12] length_saturated, [44:13] start_offset, zero above
	output logic        m_tlast    // last_of_run
);

	logic           valid_s1;
	logic           cmd_s1;
	logic [7:0]     char_s1;
	logic           take_s1;
	logic           room2;
	kts_pkg::push_t push;
	kts_pkg::res_t  out_res;

	assign take_s1  = valid_s1 && room2;
	assign s_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	kts_scan #(
		.LENGTH_LIMIT(LENGTH_LIMIT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_fire(take_s1),
		.cmd      (cmd_s1),
		.char_code(char_s1),
		.push     (push)
	);

	kts_rqueue u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_en  (take_s1),
		.room2    (room2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {3'b000, out_res.offset, out_res.sat, out_res.length, out_res.kind};
	assign m_tlast = out_res.last;

endmodule

// File: hw/rtl/kts_scan.sv
module kts_scan #(
	parameter int LENGTH_LIMIT = 255,
	parameter int OFFSET_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_fire,
	input  logic            cmd,
	input  logic [7:0]      char_code,
	output kts_pkg::push_t  push
);

	localparam int CapInt = (LENGTH_LIMIT < 255) ? LENGTH_LIMIT : 255;
	localparam logic [7:0] LenCap = 8'(CapInt);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_WORD   = 2'd2,
		MODE_COLON  = 2'd3
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [55:0]            window_q, window_d;
	logic [7:0]             run_len_q, run_len_d;
	logic                   ovf_q, ovf_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] counter_q, counter_d;

	logic           is_digit, is_letter, is_blank;
	kts_pkg::res_t  closed_tok, single_tok;
	kts_pkg::kind_t single_kind;

	assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
	                   ((char_code >= 8'h61) && (char_code <= 8'h7A));
	assign is_blank  = (char_code == kts_pkg::CH_SPACE) || (char_code == kts_pkg::CH_CR) ||
	                   (char_code == kts_pkg::CH_LF) || (char_code == kts_pkg::CH_TAB);

	always_comb begin
		priority if (char_code == kts_pkg::CH_COMMA) single_kind = kts_pkg::KIND_COMMA;
		else if (char_code == kts_pkg::CH_DOT) single_kind = kts_pkg::KIND_DOT;
		else if (char_code == kts_pkg::CH_SEMI) single_kind = kts_pkg::KIND_SEMI;
		else if (char_code == kts_pkg::CH_EQUALS) single_kind = kts_pkg::KIND_EQUALS;
		else single_kind = kts_pkg::KIND_UNKNOWN;
	end

	always_comb begin
		closed_tok.offset = 32'(start_q);
		closed_tok.last   = 1'b1;
		unique case (mode_q)
			MODE_NUMBER: begin
				closed_tok.kind   = kts_pkg::KIND_CONSTANT;
				closed_tok.length = run_len_q;
				closed_tok.sat    = ovf_q;
			end
			MODE_WORD: begin
				closed_tok.kind   = kts_pkg::word_kind(window_q, run_len_q, ovf_q);
				closed_tok.length = run_len_q;
				closed_tok.sat    = ovf_q;
			end
			default: begin
				closed_tok.kind   = kts_pkg::KIND_COLON;
				closed_tok.length = 8'd1;
				closed_tok.sat    = 1'b0;
			end
		endcase
		single_tok.kind   = single_kind;
		single_tok.length = 8'd1;
		single_tok.sat    = 1'b0;
		single_tok.offset = 32'(counter_q);
		single_tok.last   = 1'b1;
	end

	always_comb begin
		mode_d    = mode_q;
		window_d  = window_q;
		run_len_d = run_len_q;
		ovf_d     = ovf_q;
		start_d   = start_q;
		counter_d = counter_q;
		push      = '0;
		push.r0   = closed_tok;
		push.r1   = single_tok;
		if (cmd) begin
			mode_d     = MODE_IDLE;
			push.push0 = (mode_q != MODE_IDLE);
		end else begin
			counter_d = counter_q + 1'b1;
			if ((mode_q == MODE_NUMBER && is_digit) ||
			    (mode_q == MODE_WORD && (is_digit || is_letter))) begin
				if (run_len_q < 8'd7)
					window_d = {window_q[47:0], char_code};
				if (run_len_q < LenCap)
					run_len_d = run_len_q + 8'd1;
				else
					ovf_d = 1'b1;
			end else if (mode_q == MODE_COLON && char_code == kts_pkg::CH_EQUALS) begin
				mode_d            = MODE_IDLE;
				push.push0        = 1'b1;
				push.r0.kind      = kts_pkg::KIND_ASSIGN;
				push.r0.length    = 8'd2;
				push.r0.sat       = 1'b0;
			end else begin
				mode_d = MODE_IDLE;
				if (is_digit || is_letter || char_code == kts_pkg::CH_COLON) begin
					priority if (is_digit) mode_d = MODE_NUMBER;
					else if (is_letter) mode_d = MODE_WORD;
					else mode_d = MODE_COLON;
					window_d  = {48'd0, char_code};
					run_len_d = 8'd1;
					ovf_d     = 1'b0;
					start_d   = counter_q;
				end
				if (!is_blank && !is_digit && !is_letter && char_code != kts_pkg::CH_COLON) begin
					// A one-character token follows any pending token it closes.
					if (mode_q != MODE_IDLE) begin
						push.push0   = 1'b1;
						push.push1   = 1'b1;
						push.r0.last = 1'b0;
					end else begin
						push.push0 = 1'b1;
						push.r0    = single_tok;
					end
				end else begin
					push.push0 = (mode_q != MODE_IDLE);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			window_q  <= '0;
			run_len_q <= '0;
			ovf_q     <= 1'b0;
			start_q   <= '0;
			counter_q <= '0;
		end else if (item_fire) begin
			mode_q    <= mode_d;
			window_q  <= window_d;
			run_len_q <= run_len_d;
			ovf_q     <= ovf_d;
			start_q   <= start_d;
			counter_q <= counter_d;
		end
	end

	a_flush_idles: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && cmd |=> mode_q == MODE_IDLE)
		else $error("scanner not idle after flush");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_NUMBER || mode_q == MODE_WORD) |-> run_len_q != 8'd0)
		else $error("pending run with zero length");

	a_flush_no_advance: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && cmd |=> $stable(counter_q))
		else $error("flush moved the character offset");

	a_ovf_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && mode_q != MODE_IDLE |-> run_len_q == LenCap)
		else $error("overflow flag set below the length cap");

endmodule

// File: hw/rtl/kts_rqueue.sv
module kts_rqueue (
	input  logic           clk,
	input  logic           arst_n,
	input  kts_pkg::push_t push,
	input  logic           push_en,
	output logic           room2,
	output logic           out_valid,
	input  logic           out_ready,
	output kts_pkg::res_t  out_res
);

	kts_pkg::res_t                  mem_q [kts_pkg::QUEUE_DEPTH];
	logic [kts_pkg::QPTR_BITS-1:0]  head_q, tail_q;
	logic [kts_pkg::QPTR_BITS:0]    count_q;
	logic                           pop, wr0, wr1;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign wr0       = push_en && push.push0;
	assign wr1       = push_en && push.push1;
	// Two free entries are needed, counting the one a pop frees this cycle.
	assign room2     = (count_q <= (kts_pkg::QPTR_BITS+1)'(kts_pkg::QUEUE_DEPTH - 2)) ||
	                   ((count_q == (kts_pkg::QPTR_BITS+1)'(kts_pkg::QUEUE_DEPTH - 1)) && pop);

	always_ff @(posedge clk) begin
		if (wr0)
			mem_q[tail_q] <= push.r0;
		if (wr1)
			mem_q[tail_q + 1'b1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + 1'b1;
			tail_q  <= tail_q + {1'b0, wr0} + {1'b0, wr1};
			count_q <= count_q + {2'b0, wr0} + {2'b0, wr1} - {2'b0, pop};
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (kts_pkg::QPTR_BITS+1)'(kts_pkg::QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr1 |-> wr0)
		else $error("second token pushed without the first");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> room2)
		else $error("transaction taken without queue space");

endmodule
